### hdl/abd_pkg.sv
package abd_pkg;

    localparam int RING_DEPTH       = 512;
    localparam int SAMPLE_PERIOD_MS = 2;

    localparam int AXIS_W = 16;
    localparam int SUM_W  = 17;
    localparam int WIN_W  = 16;
    localparam int TIME_W = 32;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int ACC_W  = SUM_W + $clog2(RING_DEPTH);
    localparam int STEP_W = $clog2(ACC_W + 1);

    localparam int IN_W    = 3 * AXIS_W + TIME_W;
    localparam int IN_PADW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 2 * SUM_W;
    localparam int OUT_PADW = ((OUT_W + 7) / 8) * 8;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_DETECT_MODE = 3'd0;
    localparam logic [2:0] REG_SPIKE_THR   = 3'd1;
    localparam logic [2:0] REG_WINDOW_MS   = 3'd2;
    localparam logic [2:0] REG_AVG_THR     = 3'd3;
    localparam logic [2:0] REG_COOLDOWN_MS = 3'd4;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } div_rsp_t;

    // Absolute value of a signed Q8.8 axis; the most negative code gives 32768.
    function automatic logic [SUM_W-1:0] abs_axis(input logic [AXIS_W-1:0] raw);
        logic [SUM_W-1:0] ext;
        ext = {raw[AXIS_W-1], raw};
        if (raw[AXIS_W-1]) begin
            return SUM_W'(0) - ext;
        end
        return ext;
    endfunction

endpackage

### hdl/abd_ring.sv
module abd_ring (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [abd_pkg::PTR_W-1:0]   wr_addr,
    input  logic [abd_pkg::SUM_W-1:0]   wr_data,
    input  logic                        rd_en,
    input  logic [abd_pkg::PTR_W-1:0]   rd_addr,
    output logic [abd_pkg::SUM_W-1:0]   rd_data
);

    logic [abd_pkg::SUM_W-1:0] mem [abd_pkg::RING_DEPTH];
    logic [abd_pkg::SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/abd_div.sv
module abd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  abd_pkg::div_req_t req,
    output abd_pkg::div_rsp_t rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [abd_pkg::STEP_W-1:0]  step_reg;
    logic [abd_pkg::CNT_W-1:0]   rem_reg;
    logic [abd_pkg::ACC_W-1:0]   quo_reg;
    logic [abd_pkg::CNT_W-1:0]   dvs_reg;

    logic [abd_pkg::CNT_W:0]     shifted;
    logic                        fits;
    logic [abd_pkg::CNT_W-1:0]   rem_next;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        shifted  = {rem_reg, quo_reg[abd_pkg::ACC_W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? abd_pkg::CNT_W'(shifted - {1'b0, dvs_reg})
                        : shifted[abd_pkg::CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= abd_pkg::STEP_W'(abd_pkg::ACC_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == abd_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[abd_pkg::ACC_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/accel_bite_detector.sv
// Channel   Direction  Payload (low bit first)                       Accept
// s_        in         tdata: accel_x, accel_y, accel_z, time_ms     s_tvalid & s_tready
//                      tuser: sample_ok
// m_        out        tdata: axis_sum, window_average               m_tvalid & m_tready
//                      tuser: detected, catch_event
// APB       in/out     five registers at byte addresses 0, 4 .. 16   psel & penable & pwrite
//
// A valid request writes the ring, reads each averaged entry through the ring's
// single read port and sums it, runs the iterative divider when the window is
// not empty, and then decides; only then is the next request accepted.
// s_tready is high only while the sequencer is idle. A request with sample_ok
// low is consumed at its handshake and gives no result.
// A finished result waits in the output register while a new request is taken;
// the next result stalls until it has been taken. Reset is synchronous, active
// low; the ring contents are not cleared, the fill count keeps reads in range.
module accel_bite_detector (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [abd_pkg::IN_PADW-1:0]     s_tdata,  // accel_x, accel_y, accel_z, time_ms
    input  logic                            s_tuser,  // sample_ok

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [abd_pkg::OUT_PADW-1:0]    m_tdata,  // axis_sum, window_average, zero pad
    output logic [1:0]                      m_tuser,  // detected, catch_event

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [abd_pkg::APB_AW-1:0]      paddr,
    input  logic [abd_pkg::APB_DW-1:0]      pwdata,
    output logic [abd_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam int SUM_W  = abd_pkg::SUM_W;
    localparam int PTR_W  = abd_pkg::PTR_W;
    localparam int CNT_W  = abd_pkg::CNT_W;
    localparam int ACC_W  = abd_pkg::ACC_W;
    localparam int WIN_W  = abd_pkg::WIN_W;
    localparam int TIME_W = abd_pkg::TIME_W;
    localparam int AXIS_W = abd_pkg::AXIS_W;

    // Configuration registers.
    logic                   detect_mode_reg;
    logic [SUM_W-1:0]       spike_thr_reg;
    logic [WIN_W-1:0]       window_ms_reg;
    logic [SUM_W-1:0]       avg_thr_reg;
    logic [TIME_W-1:0]      cooldown_ms_reg;

    logic                   cfg_write;
    logic [2:0]             cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_mode_reg <= 1'b1;
            spike_thr_reg   <= SUM_W'(768);
            window_ms_reg   <= WIN_W'(200);
            avg_thr_reg     <= SUM_W'(512);
            cooldown_ms_reg <= TIME_W'(1000);
        end else if (cfg_write) begin
            case (cfg_index)
                abd_pkg::REG_DETECT_MODE: detect_mode_reg <= pwdata[0];
                abd_pkg::REG_SPIKE_THR:   spike_thr_reg   <= pwdata[SUM_W-1:0];
                abd_pkg::REG_WINDOW_MS:   window_ms_reg   <= pwdata[WIN_W-1:0];
                abd_pkg::REG_AVG_THR:     avg_thr_reg     <= pwdata[SUM_W-1:0];
                abd_pkg::REG_COOLDOWN_MS: cooldown_ms_reg <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            abd_pkg::REG_DETECT_MODE: prdata = abd_pkg::APB_DW'(detect_mode_reg);
            abd_pkg::REG_SPIKE_THR:   prdata = abd_pkg::APB_DW'(spike_thr_reg);
            abd_pkg::REG_WINDOW_MS:   prdata = abd_pkg::APB_DW'(window_ms_reg);
            abd_pkg::REG_AVG_THR:     prdata = abd_pkg::APB_DW'(avg_thr_reg);
            abd_pkg::REG_COOLDOWN_MS: prdata = abd_pkg::APB_DW'(cooldown_ms_reg);
            default:                  prdata = '0;
        endcase
    end

    // Sequencer state.
    state_t                 state_reg;
    logic [PTR_W-1:0]       write_pos_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [TIME_W-1:0]      last_catch_reg;
    logic [CNT_W-1:0]       issue_reg;
    logic                   pending_reg;
    logic [PTR_W-1:0]       rd_addr_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [CNT_W-1:0]       samples_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       avg_reg;
    logic [TIME_W-1:0]      time_reg;

    logic                   m_valid_reg;
    logic [SUM_W-1:0]       m_sum_reg;
    logic [SUM_W-1:0]       m_avg_reg;
    logic                   m_det_reg;
    logic                   m_catch_reg;

    logic                   in_take;
    logic                   in_valid_sample;
    logic [SUM_W-1:0]       sum_in;
    logic [CNT_W-1:0]       fill_next;
    logic [WIN_W-1:0]       win_samples;
    logic [CNT_W-1:0]       samples_next;
    logic [PTR_W-1:0]       pos_inc;
    logic [PTR_W-1:0]       addr_dec;
    logic                   rd_en;
    logic [SUM_W-1:0]       rd_data;
    logic                   walk_done;
    logic                   out_free;
    logic                   det;
    logic [TIME_W-1:0]      elapsed;
    logic                   caught;
    abd_pkg::div_req_t      div_req;
    abd_pkg::div_rsp_t      div_rsp;

    assign s_tready        = (state_reg == ST_IDLE);
    assign in_take         = s_tvalid && s_tready;
    assign in_valid_sample = in_take && s_tuser;

    assign sum_in = abd_pkg::abs_axis(s_tdata[AXIS_W-1:0])
                  + abd_pkg::abs_axis(s_tdata[2*AXIS_W-1:AXIS_W])
                  + abd_pkg::abs_axis(s_tdata[3*AXIS_W-1:2*AXIS_W]);

    always_comb begin
        fill_next = (fill_reg < CNT_W'(abd_pkg::RING_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
        win_samples = WIN_W'(window_ms_reg / abd_pkg::SAMPLE_PERIOD_MS);
        if (win_samples > WIN_W'(fill_next)) begin
            samples_next = fill_next;
        end else begin
            samples_next = CNT_W'(win_samples);
        end
        pos_inc  = (write_pos_reg == PTR_W'(abd_pkg::RING_DEPTH - 1))
                 ? '0 : write_pos_reg + 1'b1;
        addr_dec = (rd_addr_reg == '0)
                 ? PTR_W'(abd_pkg::RING_DEPTH - 1) : rd_addr_reg - 1'b1;
    end

    assign rd_en     = (state_reg == ST_WALK) && (issue_reg != '0);
    assign walk_done = (state_reg == ST_WALK) && (issue_reg == '0) && !pending_reg;

    assign div_req.start    = walk_done && (samples_reg != '0);
    assign div_req.dividend = acc_reg;
    assign div_req.divisor  = samples_reg;

    abd_ring u_ring (
        .aclk    (aclk),
        .wr_en   (in_valid_sample),
        .wr_addr (write_pos_reg),
        .wr_data (sum_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    abd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Decision logic, evaluated in the final state.
    always_comb begin
        det     = detect_mode_reg ? (avg_reg >= avg_thr_reg) : (sum_reg > spike_thr_reg);
        elapsed = time_reg - last_catch_reg;
        caught  = det && !((last_catch_reg != '0) && (elapsed < cooldown_ms_reg));
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            write_pos_reg  <= '0;
            fill_reg       <= '0;
            last_catch_reg <= '0;
            issue_reg      <= '0;
            pending_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid_sample) begin
                        write_pos_reg <= pos_inc;
                        fill_reg      <= fill_next;
                        issue_reg     <= samples_next;
                        pending_reg   <= 1'b0;
                        state_reg     <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    pending_reg <= rd_en;
                    if (rd_en) begin
                        issue_reg <= issue_reg - 1'b1;
                    end
                    if (walk_done) begin
                        state_reg <= (samples_reg != '0) ? ST_DIV : ST_FINISH;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        if (caught) begin
                            last_catch_reg <= time_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_valid_sample) begin
            sum_reg     <= sum_in;
            time_reg    <= s_tdata[3*AXIS_W+TIME_W-1:3*AXIS_W];
            samples_reg <= samples_next;
            rd_addr_reg <= write_pos_reg;
            acc_reg     <= '0;
            avg_reg     <= '0;
        end else begin
            if (rd_en) begin
                rd_addr_reg <= addr_dec;
            end
            if (pending_reg) begin
                acc_reg <= acc_reg + ACC_W'(rd_data);
            end
            if ((state_reg == ST_DIV) && div_rsp.done) begin
                avg_reg <= div_rsp.quotient[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FINISH) && out_free) begin
            m_sum_reg   <= sum_reg;
            m_avg_reg   <= avg_reg;
            m_det_reg   <= det;
            m_catch_reg <= caught;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(abd_pkg::OUT_PADW - abd_pkg::OUT_W)'(0), m_avg_reg, m_sum_reg};
    assign m_tuser  = {m_catch_reg, m_det_reg};

endmodule

### test/tb_accel_bite_detector.sv
module tb_accel_bite_detector;

    localparam logic       MODE_SPIKE   = 1'b0;
    localparam logic       MODE_AVERAGE = 1'b1;
    localparam logic [2:0] REG_UNUSED   = 3'd7;
    localparam int         SUM_MAX      = 98304;
    localparam int         SETTLE_CYCLES = 600;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 120;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [abd_pkg::IN_PADW-1:0]  s_tdata = '0;
    logic                         s_tuser = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [abd_pkg::OUT_PADW-1:0] m_tdata;
    logic [1:0]                   m_tuser;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [abd_pkg::APB_AW-1:0]   paddr = '0;
    logic [abd_pkg::APB_DW-1:0]   pwdata = '0;
    logic [abd_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    typedef struct {
        logic [abd_pkg::SUM_W-1:0] axis_sum;
        logic [abd_pkg::SUM_W-1:0] window_average;
        logic                      detected;
        logic                      catch_event;
    } detector_report_t;

    class detector_scoreboard;
        logic [abd_pkg::SUM_W-1:0]  sum_history[abd_pkg::RING_DEPTH];
        int unsigned                next_slot;
        int unsigned                filled;
        logic [31:0]                last_catch_ms;
        logic                       mode;
        logic [abd_pkg::SUM_W-1:0]  spike_thr;
        logic [abd_pkg::WIN_W-1:0]  window_ms;
        logic [abd_pkg::SUM_W-1:0]  avg_thr;
        logic [31:0]                cooldown_ms;
        detector_report_t           expected_reports[$];
        int unsigned                failures;

        function new();
            next_slot = 0;
            filled = 0;
            last_catch_ms = '0;
            mode = MODE_AVERAGE;
            spike_thr = 17'd768;
            window_ms = 16'd200;
            avg_thr = 17'd512;
            cooldown_ms = 32'd1000;
            failures = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                abd_pkg::REG_DETECT_MODE: mode = value[0];
                abd_pkg::REG_SPIKE_THR:   spike_thr = value[abd_pkg::SUM_W-1:0];
                abd_pkg::REG_WINDOW_MS:   window_ms = value[abd_pkg::WIN_W-1:0];
                abd_pkg::REG_AVG_THR:     avg_thr = value[abd_pkg::SUM_W-1:0];
                abd_pkg::REG_COOLDOWN_MS: cooldown_ms = value;
                default: ;
            endcase
        endfunction

        function logic [abd_pkg::SUM_W-1:0] magnitude(logic [abd_pkg::AXIS_W-1:0] raw);
            if (raw[abd_pkg::AXIS_W-1]) begin
                return 17'h10000 - {1'b0, raw};
            end
            return {1'b0, raw};
        endfunction

        function void take_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                  logic ok, logic [31:0] stamp);
            detector_report_t  rep;
            int unsigned       span;
            longint unsigned   total;
            logic [31:0]       elapsed;
            if (!ok) begin
                return;
            end
            rep.axis_sum = magnitude(ax) + magnitude(ay) + magnitude(az);
            sum_history[next_slot] = rep.axis_sum;
            next_slot = (next_slot + 1) % abd_pkg::RING_DEPTH;
            if (filled < abd_pkg::RING_DEPTH) begin
                filled++;
            end
            span = window_ms / abd_pkg::SAMPLE_PERIOD_MS;
            if (span > filled) begin
                span = filled;
            end
            total = 0;
            for (int i = 0; i < span; i++) begin
                total += sum_history[(next_slot + abd_pkg::RING_DEPTH - 1 - i)
                                     % abd_pkg::RING_DEPTH];
            end
            rep.window_average = (span == 0) ? '0 : abd_pkg::SUM_W'(total / span);
            if (mode == MODE_SPIKE) begin
                rep.detected = rep.axis_sum > spike_thr;
            end else begin
                rep.detected = rep.window_average >= avg_thr;
            end
            rep.catch_event = 1'b0;
            elapsed = stamp - last_catch_ms;
            if (rep.detected && !(last_catch_ms != 0 && elapsed < cooldown_ms)) begin
                last_catch_ms = stamp;
                rep.catch_event = 1'b1;
            end
            expected_reports.push_back(rep);
        endfunction

        function void check_report(logic [abd_pkg::SUM_W-1:0] sum,
                                   logic [abd_pkg::SUM_W-1:0] avg,
                                   logic det, logic caught);
            detector_report_t want;
            if (expected_reports.size() == 0) begin
                $error("unexpected result: axis_sum %0d window_average %0d", sum, avg);
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            if (sum !== want.axis_sum) begin
                $error("axis_sum: expected %0d, got %0d", want.axis_sum, sum);
                failures++;
            end
            if (avg !== want.window_average) begin
                $error("window_average: expected %0d, got %0d", want.window_average, avg);
                failures++;
            end
            if (det !== want.detected) begin
                $error("detected: expected %0b, got %0b", want.detected, det);
                failures++;
            end
            if (caught !== want.catch_event) begin
                $error("catch_event: expected %0b, got %0b", want.catch_event, caught);
                failures++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    detector_scoreboard sb = new();

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          stall_run = 0;
    logic [31:0] now_ms = '0;

    accel_bite_detector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Result side: random stalls, with an occasional long back-pressure burst.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_report(m_tdata[abd_pkg::SUM_W-1:0],
                            m_tdata[2*abd_pkg::SUM_W-1:abd_pkg::SUM_W],
                            m_tuser[0], m_tuser[1]);
        end
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            m_tready <= 1'b0;
        end else if (sink_stall_pct > 0 && $urandom_range(63) == 0) begin
            stall_run <= $urandom_range(200);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic ok,
                               input logic [31:0] stamp);
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, az, ay, ax};
        s_tuser <= ok;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_sample(ax, ay, az, ok, stamp);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        if (sb.pending() != 0) begin
            s_tvalid <= 1'b0;
            while (sb.pending() != 0) @(posedge aclk);
        end
    endtask

    // An ignored request may still be in flight after the last result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic idle_gap();
        int n;
        n = 0;
        while ($urandom_range(99) < src_idle_pct) n++;
        if (src_idle_pct > 0 && $urandom_range(31) == 0) begin
            n += $urandom_range(1, 400);
        end
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] random_axis();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 800)) - 400);
            2: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic logic [16:0] random_threshold();
        case ($urandom_range(4))
            0: return 17'd0;
            1: return 17'(SUM_MAX);
            2: return 17'($urandom_range(0, SUM_MAX));
            default: return 17'($urandom_range(0, 30000));
        endcase
    endfunction

    task automatic randomize_config(input logic long_window);
        logic [15:0] win;
        logic [31:0] cool;
        if (long_window) begin
            case ($urandom_range(3))
                0: win = 16'hFFFF;
                1: win = 16'd1024;
                2: win = 16'd1023;
                default: win = 16'($urandom_range(600, 65535));
            endcase
        end else begin
            case ($urandom_range(4))
                0: win = 16'd0;
                1: win = 16'd1;
                2: win = 16'd3;
                default: win = 16'($urandom_range(2, 64));
            endcase
        end
        case ($urandom_range(3))
            0: cool = 32'd0;
            1: cool = 32'hFFFF_FFFF;
            2: cool = $urandom_range(0, 100);
            default: cool = $urandom;
        endcase
        apb_write(abd_pkg::REG_DETECT_MODE, 32'($urandom_range(1)));
        apb_write(abd_pkg::REG_SPIKE_THR, 32'(random_threshold()));
        apb_write(abd_pkg::REG_WINDOW_MS, 32'(win));
        apb_write(abd_pkg::REG_AVG_THR, 32'(random_threshold()));
        apb_write(abd_pkg::REG_COOLDOWN_MS, cool);
    endtask

    task automatic random_samples(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            idle_gap();
            if ($urandom_range(49) == 0) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 80) begin
                now_ms += 2;
            end else if (pick < 90) begin
                now_ms += $urandom_range(0, 3000);
            end else if (pick < 95) begin
                now_ms = $urandom;
            end else begin
                now_ms = $urandom_range(0, 3);
            end
            send_sample(random_axis(), random_axis(), random_axis(),
                        $urandom_range(99) < 88, now_ms);
        end
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
            default: begin src_idle_pct = 33; sink_stall_pct = 33; end
        endcase
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: average mode over 100 sums, threshold 512, cooldown 1000.
        send_sample(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd2);
        // A catch at time zero leaves the block as if nothing was caught yet.
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, 32'd0);
        send_sample(16'h7FFF, 16'hFFFF, 16'h0001, 1'b1, 32'd4);
        send_sample(16'h8001, 16'h0000, 16'h0100, 1'b1, 32'd500);
        send_sample(16'h0001, 16'h0002, 16'h0003, 1'b1, 32'd1004);
        send_sample(16'h1234, 16'h8765, 16'h4321, 1'b1, 32'hFFFF_FF00);
        // Elapsed time wraps through zero and stays inside the cooldown.
        send_sample(16'h1234, 16'h8765, 16'h4321, 1'b1, 32'h0000_0010);
        settle();

        apb_write(abd_pkg::REG_DETECT_MODE, 32'(MODE_SPIKE));
        apb_write(abd_pkg::REG_SPIKE_THR, 32'd0);
        apb_write(abd_pkg::REG_WINDOW_MS, 32'd0);
        apb_write(abd_pkg::REG_COOLDOWN_MS, 32'd0);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd20);
        send_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 32'd20);
        send_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 32'd20);
        settle();

        apb_write(abd_pkg::REG_SPIKE_THR, 32'(SUM_MAX));
        apb_write(abd_pkg::REG_WINDOW_MS, 32'd1);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, 32'd60);
        send_sample(16'h8000, 16'h8000, 16'h8001, 1'b1, 32'd80);
        settle();

        apb_write(abd_pkg::REG_DETECT_MODE, 32'(MODE_AVERAGE));
        apb_write(abd_pkg::REG_AVG_THR, 32'(SUM_MAX));
        apb_write(abd_pkg::REG_WINDOW_MS, 32'd4);
        apb_write(abd_pkg::REG_COOLDOWN_MS, 32'hFFFF_FFFF);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, 32'd100);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, 32'd200);
        settle();

        apb_write(abd_pkg::REG_AVG_THR, 32'd0);
        apb_write(abd_pkg::REG_WINDOW_MS, 32'd3);
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd19);
        settle();

        // The ring has wrapped before the long-window phases at the end.
        for (int p = 0; p < PHASES; p++) begin
            randomize_config(p >= PHASES - 2);
            set_idling(p);
            random_samples(PHASE_ITEMS);
            settle();
        end

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
